@@ hw/rtl/ckp_pkg.sv @@
package ckp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_POINT,
    PH_GAP,
    PH_SEEK,
    PH_WEIGHTS,
    PH_MARK,
    PH_W1,
    PH_W2,
    PH_W3,
    PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_TRIPLE = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] ST_EMPTY       = 4'd0;
  localparam logic [3:0] ST_DIRECTIVE   = 4'd1;
  localparam logic [3:0] ST_NOT_DATA    = 4'd2;
  localparam logic [3:0] ST_SINGLE      = 4'd3;
  localparam logic [3:0] ST_SEQUENCE    = 4'd4;
  localparam logic [3:0] ST_BAD_POINT   = 4'd5;
  localparam logic [3:0] ST_MANY_POINTS = 4'd6;
  localparam logic [3:0] ST_NO_SEMI     = 4'd7;
  localparam logic [3:0] ST_BAD_TRIPLE  = 4'd8;
  localparam logic [3:0] ST_MANY_TRIPLE = 4'd9;

  localparam logic [23:0] CODE_LIMIT = 24'h10FFFF;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic        item_v;
    logic        item_triple;
    logic [20:0] code_point;
    logic [3:0]  position;
    logic        dot_marker;
    logic [15:0] primary_weight;
    logic [15:0] secondary_weight;
    logic [15:0] tertiary_weight;
    logic        stat_v;
    logic [3:0]  line_status;
    logic [2:0]  point_count;
    logic [4:0]  triple_count;
  } step_t;

endpackage

@@ hw/rtl/ckp_front.sv @@
module ckp_front #(
  parameter int MAX_POINTS  = 4,
  parameter int MAX_TRIPLES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    text_byte,
  input  logic          ends_line,
  input  logic          q_full,
  output logic          push,
  output ckp_pkg::step_t entry
);
  import ckp_pkg::*;

  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int TW = $clog2(MAX_TRIPLES + 1);

  phase_t        ph, ph_next;
  logic [23:0]   acc, acc_next;
  logic [2:0]    dcnt, dcnt_next;
  logic [PW-1:0] pts, pts_next;
  logic [TW-1:0] trp, trp_next;
  logic [15:0]   hp, hp_next;
  logic [15:0]   hs, hs_next;
  logic          hm, hm_next;
  logic [3:0]    pst, pst_next;

  logic          ev_point, ev_triple, ev_status;
  logic [23:0]   ev_val;
  logic [3:0]    ev_pos;
  logic [3:0]    ev_code;
  logic [2:0]    ev_pcount;
  logic [4:0]    ev_tcount;

  logic          is_hex, is_blank, take;
  logic [3:0]    dv;
  logic [23:0]   shifted;

  always_comb begin
    is_hex = 1'b1;
    dv     = 4'd0;
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      dv = 4'(text_byte - 8'h30);
    end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
      dv = 4'(text_byte - 8'h57);
    end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
      dv = 4'(text_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_blank = (text_byte == CH_SPACE) || (text_byte >= CH_TAB && text_byte <= CH_CR);
  assign shifted  = {acc[19:0], dv};
  assign in_ready = !q_full && !rst;
  assign take     = in_valid && in_ready;

  always_comb begin
    ph_next   = ph;
    acc_next  = acc;
    dcnt_next = dcnt;
    pts_next  = pts;
    trp_next  = trp;
    hp_next   = hp;
    hs_next   = hs;
    hm_next   = hm;
    pst_next  = pst;
    ev_point  = 1'b0;
    ev_triple = 1'b0;
    ev_status = 1'b0;
    ev_val    = acc;
    ev_pos    = 4'(pts);
    ev_code   = ST_EMPTY;
    ev_pcount = 3'd0;
    ev_tcount = 5'd0;

    if (ph != PH_DONE && text_byte != CH_NUL) begin
      unique case (ph)
        PH_LEAD: begin
          if (is_blank) begin
          end else if (text_byte == CH_HASH) begin
            ph_next = PH_DONE; pst_next = ST_EMPTY;
          end else if (text_byte == CH_AT) begin
            ph_next = PH_DONE; pst_next = ST_DIRECTIVE;
          end else if (!is_hex) begin
            ph_next = PH_DONE; pst_next = ST_NOT_DATA;
          end else begin
            acc_next = {20'd0, dv}; dcnt_next = 3'd1; ph_next = PH_POINT;
          end
        end
        PH_POINT: begin
          if (is_hex) begin
            acc_next  = shifted;
            dcnt_next = dcnt + 3'd1;
            if (dcnt >= 3'd5) begin
              if (shifted > CODE_LIMIT) begin
                ph_next = PH_DONE; pst_next = ST_BAD_POINT;
              end else if (pts >= PW'(MAX_POINTS)) begin
                ph_next = PH_DONE; pst_next = ST_MANY_POINTS;
              end else begin
                ev_point = 1'b1; ev_val = shifted; ev_pos = 4'(pts);
                pts_next = pts + PW'(1);
                acc_next = '0; dcnt_next = '0;
                ph_next = PH_GAP;
              end
            end
          end else begin
            if (acc > CODE_LIMIT) begin
              ph_next = PH_DONE; pst_next = ST_BAD_POINT;
            end else if (pts >= PW'(MAX_POINTS)) begin
              ph_next = PH_DONE; pst_next = ST_MANY_POINTS;
            end else begin
              ev_point = 1'b1; ev_val = acc; ev_pos = 4'(pts);
              pts_next = pts + PW'(1);
              acc_next = '0; dcnt_next = '0;
              if (is_blank) ph_next = PH_GAP;
              else if (text_byte == CH_SEMI) ph_next = PH_WEIGHTS;
              else ph_next = PH_SEEK;
            end
          end
        end
        PH_GAP: begin
          if (is_hex) begin
            acc_next = {20'd0, dv}; dcnt_next = 3'd1; ph_next = PH_POINT;
          end else if (is_blank) begin
            ph_next = PH_GAP;
          end else if (text_byte == CH_SEMI) begin
            ph_next = PH_WEIGHTS;
          end else begin
            ph_next = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (text_byte == CH_SEMI) ph_next = PH_WEIGHTS;
        end
        PH_WEIGHTS: begin
          if (text_byte == CH_HASH) begin
            ph_next  = PH_DONE;
            pst_next = (pts == PW'(1)) ? ST_SINGLE : ST_SEQUENCE;
          end else if (text_byte == CH_LBRACK) begin
            acc_next = '0; dcnt_next = '0; ph_next = PH_MARK;
          end
        end
        PH_MARK: begin
          if (text_byte == CH_DOT || text_byte == CH_STAR) begin
            hm_next = (text_byte == CH_DOT);
            hp_next = '0; hs_next = '0;
            acc_next = '0; dcnt_next = '0;
            ph_next = PH_W1;
          end else begin
            ph_next = PH_DONE; pst_next = ST_BAD_TRIPLE;
          end
        end
        PH_W1, PH_W2, PH_W3: begin
          if (is_hex) begin
            if (dcnt >= 3'd4) begin
              ph_next = PH_DONE; pst_next = ST_BAD_TRIPLE;
            end else begin
              acc_next = shifted; dcnt_next = dcnt + 3'd1;
            end
          end else if (text_byte == CH_DOT && ph == PH_W1) begin
            hp_next = acc[15:0]; acc_next = '0; dcnt_next = '0; ph_next = PH_W2;
          end else if (text_byte == CH_DOT && ph == PH_W2) begin
            hs_next = acc[15:0]; acc_next = '0; dcnt_next = '0; ph_next = PH_W3;
          end else if (text_byte == CH_RBRACK && ph == PH_W3) begin
            if (trp >= TW'(MAX_TRIPLES)) begin
              ph_next = PH_DONE; pst_next = ST_MANY_TRIPLE;
            end else begin
              ev_triple = 1'b1; ev_pos = 4'(trp);
              trp_next = trp + TW'(1);
              acc_next = '0; dcnt_next = '0;
              ph_next = PH_WEIGHTS;
            end
          end else begin
            ph_next = PH_DONE; pst_next = ST_BAD_TRIPLE;
          end
        end
        default: ph_next = PH_DONE;
      endcase
    end

    if ((text_byte == CH_NUL || ends_line) && ph_next != PH_DONE) begin
      unique case (ph_next)
        PH_LEAD: pst_next = ST_EMPTY;
        PH_POINT: begin
          if (acc_next > CODE_LIMIT) begin
            pst_next = ST_BAD_POINT;
          end else if (pts_next >= PW'(MAX_POINTS)) begin
            pst_next = ST_MANY_POINTS;
          end else begin
            ev_point = 1'b1; ev_val = acc_next; ev_pos = 4'(pts_next);
            pts_next = pts_next + PW'(1);
            pst_next = ST_NO_SEMI;
          end
        end
        PH_GAP, PH_SEEK: pst_next = ST_NO_SEMI;
        PH_WEIGHTS: pst_next = (pts_next == PW'(1)) ? ST_SINGLE : ST_SEQUENCE;
        PH_MARK, PH_W1, PH_W2, PH_W3: pst_next = ST_BAD_TRIPLE;
        default: pst_next = pst_next;
      endcase
      ph_next = PH_DONE;
    end

    if (ends_line) begin
      ev_status = 1'b1;
      ev_code   = pst_next;
      if (pst_next > ST_NOT_DATA) begin
        ev_pcount = 3'(pts_next);
        ev_tcount = 5'(trp_next);
      end
      ph_next   = PH_LEAD;
      acc_next  = '0;
      dcnt_next = '0;
      pts_next  = '0;
      trp_next  = '0;
      hp_next   = '0;
      hs_next   = '0;
      hm_next   = 1'b0;
      pst_next  = ST_EMPTY;
    end
  end

  always_comb begin
    entry             = '0;
    entry.item_v      = ev_point || ev_triple;
    entry.item_triple = ev_triple;
    entry.position    = ev_pos;
    if (ev_point) begin
      entry.code_point = ev_val[20:0];
    end
    if (ev_triple) begin
      entry.dot_marker       = hm;
      entry.primary_weight   = hp;
      entry.secondary_weight = hs;
      entry.tertiary_weight  = acc[15:0];
    end
    entry.stat_v       = ev_status;
    entry.line_status  = ev_code;
    entry.point_count  = ev_pcount;
    entry.triple_count = ev_tcount;
  end

  assign push = take && (ev_point || ev_triple || ev_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_LEAD;
      acc  <= '0;
      dcnt <= '0;
      pts  <= '0;
      trp  <= '0;
      hp   <= '0;
      hs   <= '0;
      hm   <= 1'b0;
      pst  <= ST_EMPTY;
    end else if (take) begin
      ph   <= ph_next;
      acc  <= acc_next;
      dcnt <= dcnt_next;
      pts  <= pts_next;
      trp  <= trp_next;
      hp   <= hp_next;
      hs   <= hs_next;
      hm   <= hm_next;
      pst  <= pst_next;
    end
  end

endmodule

@@ hw/rtl/ckp_queue.sv @@
module ckp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ckp_pkg::step_t wr_entry,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output ckp_pkg::step_t rd_entry
);
  import ckp_pkg::*;

  localparam int AW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  step_t         slots [Q_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

@@ hw/rtl/ckp_back.sv @@
module ckp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ckp_pkg::step_t q_entry,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [20:0]    code_point,
  output logic [3:0]     position,
  output logic           dot_marker,
  output logic [15:0]    primary_weight,
  output logic [15:0]    secondary_weight,
  output logic [15:0]    tertiary_weight,
  output logic [3:0]     line_status,
  output logic [2:0]     point_count,
  output logic [4:0]     triple_count,
  output logic           last
);
  import ckp_pkg::*;

  step_t cur;
  logic  cur_v;
  logic  sub;
  logic  show_stat;
  logic  final_beat;
  logic  done;

  assign show_stat  = !cur.item_v || sub;
  assign final_beat = show_stat || !cur.stat_v;
  assign done       = cur_v && out_ready && final_beat;
  assign q_pop      = q_valid && (!cur_v || done);
  assign out_valid  = cur_v;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
      sub   <= 1'b0;
    end else if (q_pop) begin
      cur_v <= 1'b1;
      sub   <= 1'b0;
    end else if (done) begin
      cur_v <= 1'b0;
      sub   <= 1'b0;
    end else if (cur_v && out_ready) begin
      sub   <= 1'b1;
    end
  end

  always_comb begin
    kind             = KIND_STATUS;
    code_point       = '0;
    position         = '0;
    dot_marker       = 1'b0;
    primary_weight   = '0;
    secondary_weight = '0;
    tertiary_weight  = '0;
    line_status      = '0;
    point_count      = '0;
    triple_count     = '0;
    last             = 1'b1;
    if (show_stat) begin
      line_status  = cur.line_status;
      point_count  = cur.point_count;
      triple_count = cur.triple_count;
    end else begin
      kind             = cur.item_triple ? KIND_TRIPLE : KIND_POINT;
      code_point       = cur.code_point;
      position         = cur.position;
      dot_marker       = cur.dot_marker;
      primary_weight   = cur.primary_weight;
      secondary_weight = cur.secondary_weight;
      tertiary_weight  = cur.tertiary_weight;
      last             = !cur.stat_v;
    end
  end

endmodule

@@ hw/rtl/collation_key_line_parser.sv @@
// Collation table line parser.
// Input channel: one text byte per beat (text_byte, ends_line) on in_valid /
// in_ready. Output channel: result beats on out_valid / out_ready, each a
// code point (kind 0), a weight triple (kind 1) or a line status (kind 2);
// last marks the final result caused by an input byte.
// One input byte is taken per cycle while the result queue has room. A byte
// is parsed in the cycle it is accepted; its results enter a four-entry
// queue and move from there into the output register. A byte that yields
// both an item and a status occupies the output for two beats, one per
// cycle while out_ready is high. Throughput is one byte per cycle while
// out_ready stays high, limited by the single output beat per cycle when
// bytes produce two results back to back.
// Reset clears the parse state to line start and empties the queue and the
// output register; no item is taken during reset.
// When the receiver stalls, the output holds its beat, the queue fills, and
// in_ready drops once the queue is full; parsing resumes as beats drain.
module collation_key_line_parser #(
  parameter int MAX_POINTS  = 4,
  parameter int MAX_TRIPLES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        ends_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [20:0] code_point,
  output logic [3:0]  position,
  output logic        dot_marker,
  output logic [15:0] primary_weight,
  output logic [15:0] secondary_weight,
  output logic [15:0] tertiary_weight,
  output logic [3:0]  line_status,
  output logic [2:0]  point_count,
  output logic [4:0]  triple_count,
  output logic        last
);
  import ckp_pkg::*;

  step_t wr_entry;
  step_t rd_entry;
  logic  push;
  logic  full;
  logic  pop;
  logic  rd_valid;

  ckp_front #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_TRIPLES(MAX_TRIPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .text_byte(text_byte),
    .ends_line(ends_line),
    .q_full   (full),
    .push     (push),
    .entry    (wr_entry)
  );

  ckp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .full    (full),
    .pop     (pop),
    .rd_valid(rd_valid),
    .rd_entry(rd_entry)
  );

  ckp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (rd_valid),
    .q_entry         (rd_entry),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .code_point      (code_point),
    .position        (position),
    .dot_marker      (dot_marker),
    .primary_weight  (primary_weight),
    .secondary_weight(secondary_weight),
    .tertiary_weight (tertiary_weight),
    .line_status     (line_status),
    .point_count     (point_count),
    .triple_count    (triple_count),
    .last            (last)
  );

endmodule

@@ tb/sv/collation_key_line_parser_test.sv @@
module collation_key_line_parser_test;
  import ckp_pkg::*;

  localparam int MAX_POINTS = 4;
  localparam int MAX_TRIPLES = 16;
  localparam int RANDOM_BYTES = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [3:0]  position;
    logic        dot_marker;
    logic [15:0] primary_weight;
    logic [15:0] secondary_weight;
    logic [15:0] tertiary_weight;
    logic [3:0]  line_status;
    logic [2:0]  point_count;
    logic [4:0]  triple_count;
    logic        last;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ends;
  } text_beat_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_MARKER,
    FLAW_FIFTH_DIGIT,
    FLAW_EARLY_CLOSE,
    FLAW_EXTRA_DOT
  } triple_flaw_t;

  class line_scoreboard;
    phase_t          ph;
    logic [23:0]     acc;
    int unsigned     ndig;
    int unsigned     npts;
    int unsigned     ntri;
    logic [15:0]     held_pri;
    logic [15:0]     held_sec;
    logic            held_dot;
    logic [3:0]      pending;
    parse_result_t   due_q[$];
    parse_result_t   step_q[$];
    int unsigned     fails;

    function new();
      clear_line();
      fails = 0;
    endfunction

    function void clear_line();
      ph = PH_LEAD;
      acc = '0;
      ndig = 0;
      npts = 0;
      ntri = 0;
      held_pri = '0;
      held_sec = '0;
      held_dot = 1'b0;
      pending = ST_EMPTY;
    endfunction

    function void stash(parse_result_t r);
      if (step_q.size() < 2) step_q.push_back(r);
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void decide(logic [3:0] st);
      pending = st;
      ph = PH_DONE;
    endfunction

    function bit close_point();
      parse_result_t r;
      if (acc > CODE_LIMIT) begin
        decide(ST_BAD_POINT);
        return 1'b0;
      end
      if (npts >= MAX_POINTS) begin
        decide(ST_MANY_POINTS);
        return 1'b0;
      end
      r = '{default: '0};
      r.kind = KIND_POINT;
      r.code_point = acc[20:0];
      r.position = 4'(npts);
      stash(r);
      npts++;
      acc = '0;
      ndig = 0;
      return 1'b1;
    endfunction

    function void between_points(logic [7:0] c);
      int d;
      d = hex_val(c);
      if (d >= 0) begin
        acc = 24'(d);
        ndig = 1;
        ph = PH_POINT;
      end else if (blank(c)) begin
        ph = PH_GAP;
      end else if (c == CH_SEMI) begin
        ph = PH_WEIGHTS;
      end else begin
        ph = PH_SEEK;
      end
    endfunction

    function void end_content();
      case (ph)
        PH_LEAD: decide(ST_EMPTY);
        PH_POINT: if (close_point()) decide(ST_NO_SEMI);
        PH_GAP, PH_SEEK: decide(ST_NO_SEMI);
        PH_WEIGHTS: decide(npts == 1 ? ST_SINGLE : ST_SEQUENCE);
        PH_MARK, PH_W1, PH_W2, PH_W3: decide(ST_BAD_TRIPLE);
        default: ph = PH_DONE;
      endcase
    endfunction

    function void take_byte(logic [7:0] c);
      int d;
      parse_result_t r;
      d = hex_val(c);
      case (ph)
        PH_LEAD: begin
          if (blank(c)) begin
          end else if (c == CH_HASH) begin
            decide(ST_EMPTY);
          end else if (c == CH_AT) begin
            decide(ST_DIRECTIVE);
          end else if (d < 0) begin
            decide(ST_NOT_DATA);
          end else begin
            between_points(c);
          end
        end
        PH_POINT: begin
          if (d >= 0) begin
            acc = {acc[19:0], 4'(d)};
            ndig++;
            if (ndig >= 6 && close_point()) ph = PH_GAP;
          end else if (close_point()) begin
            between_points(c);
          end
        end
        PH_GAP: between_points(c);
        PH_SEEK: if (c == CH_SEMI) ph = PH_WEIGHTS;
        PH_WEIGHTS: begin
          if (c == CH_HASH) begin
            decide(npts == 1 ? ST_SINGLE : ST_SEQUENCE);
          end else if (c == CH_LBRACK) begin
            acc = '0;
            ndig = 0;
            ph = PH_MARK;
          end
        end
        PH_MARK: begin
          if (c == CH_DOT || c == CH_STAR) begin
            held_dot = (c == CH_DOT);
            held_pri = '0;
            held_sec = '0;
            acc = '0;
            ndig = 0;
            ph = PH_W1;
          end else begin
            decide(ST_BAD_TRIPLE);
          end
        end
        PH_W1, PH_W2, PH_W3: begin
          if (d >= 0) begin
            if (ndig >= 4) begin
              decide(ST_BAD_TRIPLE);
            end else begin
              acc = {acc[19:0], 4'(d)};
              ndig++;
            end
          end else if (c == CH_DOT && ph == PH_W1) begin
            held_pri = acc[15:0];
            acc = '0;
            ndig = 0;
            ph = PH_W2;
          end else if (c == CH_DOT && ph == PH_W2) begin
            held_sec = acc[15:0];
            acc = '0;
            ndig = 0;
            ph = PH_W3;
          end else if (c == CH_RBRACK && ph == PH_W3) begin
            if (ntri >= MAX_TRIPLES) begin
              decide(ST_MANY_TRIPLE);
            end else begin
              r = '{default: '0};
              r.kind = KIND_TRIPLE;
              r.position = 4'(ntri);
              r.dot_marker = held_dot;
              r.primary_weight = held_pri;
              r.secondary_weight = held_sec;
              r.tertiary_weight = acc[15:0];
              stash(r);
              ntri++;
              acc = '0;
              ndig = 0;
              ph = PH_WEIGHTS;
            end
          end else begin
            decide(ST_BAD_TRIPLE);
          end
        end
        default: ph = PH_DONE;
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic ends);
      parse_result_t r;
      step_q.delete();
      if (ph != PH_DONE) begin
        if (c == CH_NUL) end_content();
        else take_byte(c);
      end
      if (ends) begin
        if (ph != PH_DONE) end_content();
        if (pending <= ST_NOT_DATA) begin
          npts = 0;
          ntri = 0;
        end
        r = '{default: '0};
        r.kind = KIND_STATUS;
        r.line_status = pending;
        r.point_count = 3'(npts);
        r.triple_count = 5'(ntri);
        stash(r);
        clear_line();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) due_q.push_back(step_q[i]);
    endfunction

    function string show(parse_result_t r);
      return $sformatf({"kind=%0d cp=%h pos=%0d dot=%0b w=%h.%h.%h status=%0d ",
                        "points=%0d triples=%0d last=%0b"},
                       r.kind, r.code_point, r.position, r.dot_marker, r.primary_weight,
                       r.secondary_weight, r.tertiary_weight, r.line_status,
                       r.point_count, r.triple_count, r.last);
    endfunction

    function void flag(string what, parse_result_t want, parse_result_t got);
      fails++;
      if (fails <= 10)
        $display("%s\n  expected %s\n  actual   %s", what, show(want), show(got));
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (due_q.size() == 0) begin
        flag("result beat with nothing expected", '{default: '0}, got);
        return;
      end
      want = due_q.pop_front();
      if (got !== want) flag("result beat mismatch", want, got);
    endfunction

    function void flush_leftover();
      foreach (due_q[i]) flag("result beat never arrived", due_q[i], '{default: '0});
      due_q.delete();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        ends_line = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [20:0] code_point;
  logic [3:0]  position;
  logic        dot_marker;
  logic [15:0] primary_weight;
  logic [15:0] secondary_weight;
  logic [15:0] tertiary_weight;
  logic [3:0]  line_status;
  logic [2:0]  point_count;
  logic [4:0]  triple_count;
  logic        last;

  bit            calm = 1'b0;
  logic [7:0]    line_buf[$];
  text_beat_t    beat_q[$];
  line_scoreboard sb = new();

  collation_key_line_parser #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_TRIPLES(MAX_TRIPLES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .ends_line(ends_line),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .code_point(code_point),
    .position(position),
    .dot_marker(dot_marker),
    .primary_weight(primary_weight),
    .secondary_weight(secondary_weight),
    .tertiary_weight(tertiary_weight),
    .line_status(line_status),
    .point_count(point_count),
    .triple_count(triple_count),
    .last(last)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic void add_hex(int unsigned nd, logic [23:0] v);
    for (int i = nd; i > 0; i--) line_buf.push_back(hex_char(v[4 * (i - 1) +: 4]));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void end_line();
    foreach (line_buf[i])
      beat_q.push_back(text_beat_t'{ch: line_buf[i], ends: (i == line_buf.size() - 1)});
    line_buf.delete();
  endfunction

  function automatic void make_line();
    int unsigned mode, npt, ntr, nd, cut;
    triple_flaw_t flaw;
    logic [23:0] v;
    line_buf.delete();
    mode = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
    if (mode < 6) begin
      case ($urandom_range(0, 2))
        0: line_buf.push_back(CH_HASH);
        1: line_buf.push_back(CH_AT);
        default: line_buf.push_back(8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(32, 126)));
    end else if (mode < 12) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      npt = ($urandom_range(0, 99) < 6) ? 5 : $urandom_range(1, 4);
      for (int i = 0; i < npt; i++) begin
        nd = $urandom_range(1, 6);
        v = 24'($urandom);
        if (nd == 6 && $urandom_range(0, 99) >= 15) v = 24'($urandom_range(0, CODE_LIMIT));
        if ($urandom_range(0, 99) < 3) begin
          nd = 6;
          v = $urandom_range(0, 1) ? CODE_LIMIT : CODE_LIMIT + 24'd1;
        end
        add_hex(nd, v);
        if ((nd < 6 && i + 1 < npt) || $urandom_range(0, 1))
          repeat ($urandom_range(1, 2)) line_buf.push_back(blank_char());
      end
      if ($urandom_range(0, 99) < 4) line_buf.push_back(8'($urandom_range(103, 122)));
      if ($urandom_range(0, 99) >= 5) line_buf.push_back(CH_SEMI);
      ntr = ($urandom_range(0, 99) < 4) ? $urandom_range(15, 17) : $urandom_range(0, 3);
      for (int i = 0; i < ntr; i++) begin
        if ($urandom_range(0, 1)) line_buf.push_back(blank_char());
        line_buf.push_back(CH_LBRACK);
        flaw = ($urandom_range(0, 99) < 4) ? triple_flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
        if (flaw == FLAW_MARKER) line_buf.push_back(8'($urandom_range(0, 255)));
        else line_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_STAR);
        for (int k = 0; k < 3; k++) begin
          nd = (flaw == FLAW_FIFTH_DIGIT && k == 1) ? 5 : $urandom_range(0, 4);
          add_hex(nd, 24'($urandom));
          if (flaw == FLAW_EARLY_CLOSE && k == 1) break;
          if (k < 2 || flaw == FLAW_EXTRA_DOT) line_buf.push_back(CH_DOT);
        end
        line_buf.push_back(CH_RBRACK);
      end
      if ($urandom_range(0, 99) < 20) begin
        line_buf.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(32, 126)));
      end
    end
    mode = $urandom_range(0, 99);
    if (mode < 5 && line_buf.size() > 1) begin
      cut = $urandom_range(1, line_buf.size());
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end else if (mode < 9) begin
      line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
    end else if (mode < 13 && line_buf.size() > 0) begin
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if (line_buf.size() == 0 || $urandom_range(0, 1)) line_buf.push_back(blank_char());
    end_line();
  endfunction

  task automatic feed_bytes();
    for (int i = 0; i < beat_q.size(); i++) begin
      calm = (i >= 300 && i < 600);
      while (!calm && $urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      text_byte <= beat_q[i].ch;
      ends_line <= beat_q[i].ends;
      do @(posedge clk); while (!in_ready);
      sb.note_byte(beat_q[i].ch, beat_q[i].ends);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
  endtask

  always @(posedge clk) out_ready <= !rst && (calm || $urandom_range(0, 99) >= 14);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(parse_result_t'{kind, code_point, position, dot_marker, primary_weight,
                                      secondary_weight, tertiary_weight, line_status,
                                      point_count, triple_count, last});
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned directed;
    add_text("#");
    end_line();
    add_text("@");
    end_line();
    add_text("x");
    end_line();
    line_buf.push_back(8'hFF);
    end_line();
    add_text("1");
    line_buf.push_back(CH_NUL);
    add_text("2");
    end_line();
    add_text("10FFFF;[*..]");
    end_line();
    add_text("a B;[.F");
    end_line();
    directed = beat_q.size();
    while (beat_q.size() < directed + RANDOM_BYTES) make_line();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    feed_bytes();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_leftover();
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
